// ===== hdl/sra_pkg.sv =====
// Shared types and constants for the skyline rectangle allocator.
// Depends on nothing; every other file of the block imports it.
package sra_pkg;

  // Widths fixed by the word format.
  localparam int SPAN_W = 14;
  localparam int HGT_W  = 11;
  localparam int ALN_W  = 13;

  // Result status codes.
  localparam logic [1:0] STAT_PLACED  = 2'd0;
  localparam logic [1:0] STAT_CLEARED = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_NOROOM  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PADDING      = 2'd2;
  localparam logic [1:0] CFG_MAX_ATLASES  = 2'd3;

  // Default parameter values.
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_ATLAS_LIMIT = 16;

  // Item request kinds.
  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic [10:0] atlas_width;
    logic [10:0] atlas_height;
    logic [4:0]  padding;
    logic [4:0]  max_atlases;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  atlas_index;
    logic [9:0]  slot_x;
    logic [9:0]  slot_y;
    logic [12:0] aligned_width;
    logic [12:0] aligned_height;
    logic [15:0] slot_id;
    logic [15:0] fail_total;
  } res_t;

  typedef enum logic [2:0] {
    ENG_INIT,
    ENG_IDLE,
    ENG_CLR,
    ENG_RD,
    ENG_EV,
    ENG_FILL,
    ENG_DONE
  } eng_state_t;

endpackage

// ===== hdl/sra_skyline_mem.sv =====
// Single-port-write, single-port-read skyline memory with registered read data.
// Depends on sra_pkg for the entry width.
module sra_skyline_mem
  import sra_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(MAX_COLUMNS)-1:0] waddr,
  input  logic [HGT_W-1:0]               wdata,
  input  logic [$clog2(MAX_COLUMNS)-1:0] raddr,
  output logic [HGT_W-1:0]               rdata
);

  logic [HGT_W-1:0] mem [MAX_COLUMNS];
  logic [HGT_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sra_engine.sv =====
// Placement sequencer: clearing sweeps, window search and column fill.
// Depends on sra_pkg; drives the ports of sra_skyline_mem.
module sra_engine
  import sra_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int ATLAS_LIMIT = DEF_ATLAS_LIMIT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           start,
  input  logic                           kind,
  input  logic [11:0]                    rect_w,
  input  logic [11:0]                    rect_h,
  output logic                           idle,
  output logic                           res_valid,
  output res_t                           res,
  input  logic                           res_take,
  output logic                           mem_we,
  output logic [$clog2(MAX_COLUMNS)-1:0] mem_waddr,
  output logic [HGT_W-1:0]               mem_wdata,
  output logic [$clog2(MAX_COLUMNS)-1:0] mem_raddr,
  input  logic [HGT_W-1:0]               mem_rdata
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(ATLAS_LIMIT + 1);

  eng_state_t        state_r, state_nxt;
  logic [ALN_W-1:0]  aw_r, aw_nxt, ah_r, ah_nxt;
  logic [SPAN_W-1:0] reqw_r, reqw_nxt, reqh_r, reqh_nxt;
  logic [SPAN_W-1:0] ptr_r, ptr_nxt, x_r, x_nxt, s_r, s_nxt;
  logic [SPAN_W-1:0] arg_r, arg_nxt, bestx_r, bestx_nxt;
  logic [HGT_W-1:0]  runmax_r, runmax_nxt, best_r, best_nxt;
  logic              found_r, found_nxt, retry_r, retry_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [CNT_W-1:0]  acnt_r, acnt_nxt;
  logic [15:0]       id_r, id_nxt, fail_r, fail_nxt;

  logic [SPAN_W-1:0] cols, win_end, fill_end, top_sum, pad_x;
  logic [ALN_W-1:0]  in_aw, in_ah;
  logic [11:0]       pad_y;
  logic              scan_done, tall, beaten, ge, last, can_open, placed;
  logic [HGT_W-1:0]  win_max;
  logic [SPAN_W-1:0] win_arg;

  // Datapath helpers.
  always_comb begin
    cols = (SPAN_W'(cfg.atlas_width) > SPAN_W'(MAX_COLUMNS)) ? SPAN_W'(MAX_COLUMNS)
                                                             : SPAN_W'(cfg.atlas_width);
    win_end   = x_r + reqw_r;
    fill_end  = bestx_r + reqw_r;
    scan_done = win_end > cols;
    tall      = (SPAN_W'(mem_rdata) + reqh_r) > SPAN_W'(cfg.atlas_height);
    beaten    = found_r && (mem_rdata >= best_r);
    ge        = mem_rdata >= runmax_r;
    win_max   = ge ? mem_rdata : runmax_r;
    win_arg   = ge ? s_r : arg_r;
    last      = (s_r + SPAN_W'(1)) == win_end;
    top_sum   = SPAN_W'(best_r) + reqh_r;
    can_open  = (8'(acnt_r) < 8'(cfg.max_atlases)) && (8'(acnt_r) < 8'(ATLAS_LIMIT));
    in_aw     = (ALN_W'(rect_w) + ALN_W'(3)) & ~ALN_W'(3);
    in_ah     = (ALN_W'(rect_h) + ALN_W'(3)) & ~ALN_W'(3);
    pad_x     = bestx_r + SPAN_W'(cfg.padding);
    pad_y     = 12'(best_r) + 12'(cfg.padding);
  end

  // Memory port control.
  always_comb begin
    mem_we    = (state_r == ENG_INIT) || (state_r == ENG_CLR) || (state_r == ENG_FILL);
    mem_waddr = ptr_r[COL_W-1:0];
    mem_wdata = (state_r == ENG_FILL) ? top_sum[HGT_W-1:0] : '0;
    mem_raddr = s_r[COL_W-1:0];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ENG_INIT;
      ptr_r    <= '0;
      acnt_r   <= CNT_W'(1);
      id_r     <= '0;
      fail_r   <= '0;
      retry_r  <= 1'b0;
      found_r  <= 1'b0;
      status_r <= STAT_CLEARED;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      acnt_r   <= acnt_nxt;
      id_r     <= id_nxt;
      fail_r   <= fail_nxt;
      retry_r  <= retry_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
    end
  end

  // Working registers of the search.
  always_ff @(posedge clk) begin
    aw_r     <= aw_nxt;
    ah_r     <= ah_nxt;
    reqw_r   <= reqw_nxt;
    reqh_r   <= reqh_nxt;
    x_r      <= x_nxt;
    s_r      <= s_nxt;
    arg_r    <= arg_nxt;
    bestx_r  <= bestx_nxt;
    runmax_r <= runmax_nxt;
    best_r   <= best_nxt;
  end

  // Next state. A column that is too tall or no lower than the best top so far
  // rules out every window holding it; a finished window rules out every later
  // window that still holds its highest column.
  always_comb begin
    state_nxt  = state_r;
    aw_nxt     = aw_r;
    ah_nxt     = ah_r;
    reqw_nxt   = reqw_r;
    reqh_nxt   = reqh_r;
    ptr_nxt    = ptr_r;
    x_nxt      = x_r;
    s_nxt      = s_r;
    arg_nxt    = arg_r;
    bestx_nxt  = bestx_r;
    runmax_nxt = runmax_r;
    best_nxt   = best_r;
    found_nxt  = found_r;
    retry_nxt  = retry_r;
    status_nxt = status_r;
    acnt_nxt   = acnt_r;
    id_nxt     = id_r;
    fail_nxt   = fail_r;
    case (state_r)
      ENG_INIT: begin
        ptr_nxt = ptr_r + SPAN_W'(1);
        if (ptr_r == SPAN_W'(MAX_COLUMNS - 1)) begin
          state_nxt = ENG_IDLE;
        end
      end
      ENG_IDLE: begin
        if (start) begin
          retry_nxt  = 1'b0;
          found_nxt  = 1'b0;
          x_nxt      = '0;
          s_nxt      = '0;
          runmax_nxt = '0;
          ptr_nxt    = '0;
          if (kind == KIND_CLEAR) begin
            status_nxt = STAT_CLEARED;
            aw_nxt     = '0;
            ah_nxt     = '0;
            state_nxt  = ENG_CLR;
          end else if (rect_w == '0 || rect_h == '0) begin
            status_nxt = STAT_INVALID;
            aw_nxt     = '0;
            ah_nxt     = '0;
            state_nxt  = ENG_DONE;
          end else begin
            aw_nxt    = in_aw;
            ah_nxt    = in_ah;
            reqw_nxt  = SPAN_W'(in_aw) + {8'd0, cfg.padding, 1'b0};
            reqh_nxt  = SPAN_W'(in_ah) + {8'd0, cfg.padding, 1'b0};
            state_nxt = ENG_RD;
          end
        end
      end
      ENG_CLR: begin
        ptr_nxt = ptr_r + SPAN_W'(1);
        if (ptr_r == SPAN_W'(MAX_COLUMNS - 1)) begin
          if (retry_r) begin
            x_nxt      = '0;
            s_nxt      = '0;
            runmax_nxt = '0;
            found_nxt  = 1'b0;
            state_nxt  = ENG_RD;
          end else begin
            fail_nxt  = '0;
            state_nxt = ENG_DONE;
          end
        end
      end
      ENG_RD: begin
        if (scan_done) begin
          if (found_r) begin
            ptr_nxt   = bestx_r;
            state_nxt = ENG_FILL;
          end else if (!retry_r && can_open) begin
            acnt_nxt  = acnt_r + CNT_W'(1);
            retry_nxt = 1'b1;
            ptr_nxt   = '0;
            state_nxt = ENG_CLR;
          end else begin
            if (fail_r != 16'hFFFF) begin
              fail_nxt = fail_r + 16'd1;
            end
            status_nxt = STAT_NOROOM;
            state_nxt  = ENG_DONE;
          end
        end else begin
          state_nxt = ENG_EV;
        end
      end
      ENG_EV: begin
        state_nxt = ENG_RD;
        if (tall || beaten) begin
          x_nxt      = s_r + SPAN_W'(1);
          s_nxt      = s_r + SPAN_W'(1);
          runmax_nxt = '0;
        end else if (last) begin
          found_nxt  = 1'b1;
          best_nxt   = win_max;
          bestx_nxt  = x_r;
          x_nxt      = win_arg + SPAN_W'(1);
          s_nxt      = win_arg + SPAN_W'(1);
          runmax_nxt = '0;
        end else begin
          runmax_nxt = win_max;
          arg_nxt    = win_arg;
          s_nxt      = s_r + SPAN_W'(1);
        end
      end
      ENG_FILL: begin
        ptr_nxt = ptr_r + SPAN_W'(1);
        if ((ptr_r + SPAN_W'(1)) == fill_end) begin
          status_nxt = STAT_PLACED;
          state_nxt  = ENG_DONE;
        end
      end
      ENG_DONE: begin
        if (res_take) begin
          if (status_r == STAT_PLACED) begin
            id_nxt = id_r + 16'd1;
          end
          state_nxt = ENG_IDLE;
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  // Result word.
  always_comb begin
    placed             = status_r == STAT_PLACED;
    idle               = state_r == ENG_IDLE;
    res_valid          = state_r == ENG_DONE;
    res.status         = status_r;
    res.atlas_index    = 4'(acnt_r - CNT_W'(1));
    res.slot_x         = placed ? pad_x[9:0] : '0;
    res.slot_y         = placed ? pad_y[9:0] : '0;
    res.aligned_width  = aw_r;
    res.aligned_height = ah_r;
    res.slot_id        = placed ? id_r : '0;
    res.fail_total     = fail_r;
  end

endmodule

// ===== hdl/skyline_rect_allocator_core.sv =====
// Skyline rectangle allocator: one result word for every request word.
// A placement reads (ENG_RD) and compares (ENG_EV) each skyline column the search
// visits, then writes every column of the chosen window (ENG_FILL). Window tops that
// fall steadily make the search visit columns again; a padded width beyond the atlas
// ends the search at once. A clear or a fresh atlas runs a zeroing sweep over the
// whole skyline memory (ENG_CLR), and after reset the same sweep runs (ENG_INIT)
// before the first word is taken.
// One word is in work at a time; the finished result waits in an output register.
module skyline_rect_allocator_core
  import sra_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int ATLAS_LIMIT = DEF_ATLAS_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [11:0] in_rect_width,
  input  logic [11:0] in_rect_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_atlas_index,
  output logic [9:0]  out_slot_x,
  output logic [9:0]  out_slot_y,
  output logic [12:0] out_aligned_width,
  output logic [12:0] out_aligned_height,
  output logic [15:0] out_slot_id,
  output logic [15:0] out_fail_total
);

  localparam int COL_W = $clog2(MAX_COLUMNS);

  cfg_t             cfg_r;
  logic             eng_idle, res_valid, res_take;
  res_t             eng_res, out_res_r;
  logic             out_valid_r;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr, mem_raddr;
  logic [HGT_W-1:0] mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atlas_width  <= 11'd1024;
      cfg_r.atlas_height <= 11'd1024;
      cfg_r.padding      <= 5'd0;
      cfg_r.max_atlases  <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH:  cfg_r.atlas_width  <= cfg_wdata;
        CFG_ATLAS_HEIGHT: cfg_r.atlas_height <= cfg_wdata;
        CFG_PADDING:      cfg_r.padding      <= cfg_wdata[4:0];
        CFG_MAX_ATLASES:  cfg_r.max_atlases  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign in_ready = eng_idle;
  assign res_take = res_valid && (!out_valid_r || out_ready);

  sra_engine #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .ATLAS_LIMIT(ATLAS_LIMIT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_valid && eng_idle),
    .kind      (in_kind),
    .rect_w    (in_rect_width),
    .rect_h    (in_rect_height),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (eng_res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sra_skyline_mem #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_atlas_index    = out_res_r.atlas_index;
  assign out_slot_x         = out_res_r.slot_x;
  assign out_slot_y         = out_res_r.slot_y;
  assign out_aligned_width  = out_res_r.aligned_width;
  assign out_aligned_height = out_res_r.aligned_height;
  assign out_slot_id        = out_res_r.slot_id;
  assign out_fail_total     = out_res_r.fail_total;

`ifndef SYNTHESIS
  // A placed rectangle always has a nonzero rounded size.
  a_placed_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_PLACED) |-> (out_aligned_width != 13'd0 &&
                                                  out_aligned_height != 13'd0))
    else $error("placed word with zero size");

  // A clear leaves the failure count at zero.
  a_clear_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_CLEARED) |-> (out_fail_total == 16'd0))
    else $error("clear word with nonzero failure count");

  // An accepted word keeps the engine busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine idle right after accepting a word");

  // Only placed words carry coordinates.
  a_no_coord: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_PLACED) |-> (out_slot_x == 10'd0 &&
                                                  out_slot_y == 10'd0 && out_slot_id == 16'd0))
    else $error("coordinates on an unplaced word");
`endif

endmodule

// ===== tb/sv/skyline_rect_allocator_core_tb.sv =====
// Self-checking testbench for skyline_rect_allocator_core.
// Depends on sra_pkg and the allocator RTL. It drives request words and checks each
// result word against a directed table entry or an in-bench skyline predictor.
`timescale 1ns / 100ps

module skyline_rect_allocator_core_tb;
  import sra_pkg::*;

  localparam int COLS_MAX  = 1024;
  localparam int ATLAS_CAP = 16;
  localparam int STALL_CAP = 3000000;
  localparam int N_PHASES  = 5;

  typedef struct {
    logic        kind;
    logic [11:0] w;
    logic [11:0] h;
    bit          typed;
    res_t        exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_ATLAS_WIDTH;
  logic [10:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_PLACE;
  logic [11:0] in_rect_width = '0;
  logic [11:0] in_rect_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t got;

  // Predictor state: the skyline and the counters of the block.
  logic [10:0] sky [COLS_MAX];
  int unsigned cfg_cols = 1024, cfg_rows = 1024, cfg_pad = 0, cfg_maxat = 4;
  int unsigned cur_atlas = 0, atlas_total = 1, id_next = 0, fails = 0;

  res_t expected_words [$];
  int mismatches = 0;
  int n_placed = 0, n_noroom = 0, n_invalid = 0, n_cleared = 0;
  int snd_pct = 37, rcv_pct = 54;
  int idle_cnt = 0;

  always #5 clk = ~clk;

  skyline_rect_allocator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(got.status), .out_atlas_index(got.atlas_index),
    .out_slot_x(got.slot_x), .out_slot_y(got.slot_y),
    .out_aligned_width(got.aligned_width), .out_aligned_height(got.aligned_height),
    .out_slot_id(got.slot_id), .out_fail_total(got.fail_total)
  );

  function automatic void wipe_skyline();
    for (int i = 0; i < COLS_MAX; i++) sky[i] = '0;
  endfunction

  // Leftmost window whose highest column is lowest and still leaves room.
  function automatic bit find_window(int unsigned rw, int unsigned rh,
                                     output int unsigned bx, output int unsigned by);
    int unsigned cols, best, top;
    bit hit;
    cols = (cfg_cols > COLS_MAX) ? COLS_MAX : cfg_cols;
    best = 32'hFFFF_FFFF;
    hit = 1'b0;
    bx = 0;
    by = 0;
    if (rw > cols) return 1'b0;
    for (int unsigned x = 0; x + rw <= cols; x++) begin
      top = 0;
      for (int unsigned s = x; s < x + rw; s++)
        if (sky[s] > top) top = 32'(sky[s]);
      if (top + rh <= cfg_rows && top < best) begin
        best = top;
        bx = x;
        hit = 1'b1;
      end
    end
    if (hit) by = best;
    return hit;
  endfunction

  // Works out the result word of one request and advances the predictor state.
  function automatic res_t place_rect(logic kind, logic [11:0] w, logic [11:0] h);
    res_t r;
    int unsigned aw, ah, rw, rh, x, y;
    bit ok;
    r = '0;
    if (kind == KIND_CLEAR) begin
      wipe_skyline();
      fails = 0;
      r.status = STAT_CLEARED;
      r.atlas_index = cur_atlas[3:0];
      return r;
    end
    if (w == 0 || h == 0) begin
      r.status = STAT_INVALID;
      r.atlas_index = cur_atlas[3:0];
      r.fail_total = fails[15:0];
      return r;
    end
    aw = (w + 3) & ~32'd3;
    ah = (h + 3) & ~32'd3;
    rw = aw + 2 * cfg_pad;
    rh = ah + 2 * cfg_pad;
    ok = find_window(rw, rh, x, y);
    // No room: open a fresh atlas when the limits allow, then search once more.
    if (!ok && atlas_total < cfg_maxat && atlas_total < ATLAS_CAP) begin
      atlas_total++;
      cur_atlas = (atlas_total - 1) & 15;
      wipe_skyline();
      ok = find_window(rw, rh, x, y);
    end
    r.atlas_index = cur_atlas[3:0];
    r.aligned_width = aw[12:0];
    r.aligned_height = ah[12:0];
    if (!ok) begin
      if (fails < 16'hFFFF) fails++;
      r.status = STAT_NOROOM;
      r.fail_total = fails[15:0];
      return r;
    end
    for (int unsigned s = x; s < x + rw && s < COLS_MAX; s++)
      sky[s] = 11'(y + rh);
    r.status = STAT_PLACED;
    r.slot_x = 10'(x + cfg_pad);
    r.slot_y = 10'(y + cfg_pad);
    r.slot_id = id_next[15:0];
    id_next = (id_next + 1) & 16'hFFFF;
    r.fail_total = fails[15:0];
    return r;
  endfunction

  // Offers one request word, at times with a random gap ahead of it, and waits for acceptance.
  task automatic send_request(logic kind, logic [11:0] w, logic [11:0] h,
                              bit typed, res_t exp);
    res_t pred;
    if ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_rect_width <= w;
    in_rect_height <= h;
    do @(posedge clk); while (!in_ready);
    pred = place_rect(kind, w, h);
    expected_words.insert(expected_words.size(), typed ? exp : pred);
  endtask

  // Waits for every result, then rewrites all four registers.
  task automatic load_setting(int unsigned cw, int unsigned ch, int unsigned pd,
                              int unsigned ma);
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ATLAS_WIDTH;  cfg_wdata <= cw[10:0]; @(posedge clk);
    cfg_index <= CFG_ATLAS_HEIGHT; cfg_wdata <= ch[10:0]; @(posedge clk);
    cfg_index <= CFG_PADDING;      cfg_wdata <= pd[10:0]; @(posedge clk);
    cfg_index <= CFG_MAX_ATLASES;  cfg_wdata <= ma[10:0]; @(posedge clk);
    cfg_we <= 1'b0;
    cfg_cols = cw;
    cfg_rows = ch;
    cfg_pad = pd;
    cfg_maxat = ma;
  endtask

  // Receiver side: random back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word status=%0d", got.status);
      end else begin
        want = expected_words.pop_front();
        case (want.status)
          STAT_PLACED:  n_placed++;
          STAT_CLEARED: n_cleared++;
          STAT_INVALID: n_invalid++;
          default:      n_noroom++;
        endcase
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Result mismatch: exp st=%0d at=%0d x=%0d y=%0d aw=%0d ah=%0d",
                      " id=%0d ft=%0d / got st=%0d at=%0d x=%0d y=%0d aw=%0d ah=%0d",
                      " id=%0d ft=%0d"},
                     want.status, want.atlas_index, want.slot_x, want.slot_y,
                     want.aligned_width, want.aligned_height, want.slot_id,
                     want.fail_total, got.status, got.atlas_index, got.slot_x,
                     got.slot_y, got.aligned_width, got.aligned_height, got.slot_id,
                     got.fail_total);
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_CAP) begin
      $display("Watchdog expired with %0d results outstanding", expected_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases under several settings.
  initial begin
    stim_row_t dir_rows [12];
    int unsigned ph_cols [N_PHASES] = '{32, 4, 2047, 96, 16};
    int unsigned ph_rows [N_PHASES] = '{32, 4, 2047, 48, 1024};
    int unsigned ph_pad  [N_PHASES] = '{0, 0, 16, 2, 1};
    int unsigned ph_max  [N_PHASES] = '{16, 1, 16, 3, 5};
    int unsigned ph_cnt  [N_PHASES] = '{95, 30, 10, 100, 45};
    int unsigned ph_dim  [N_PHASES] = '{16, 4, 8, 24, 6};
    int n_rand;
    int pick;
    logic rk;
    logic [11:0] rw, rh;
    res_t none;

    none = '0;
    dir_rows = '{
      '{KIND_PLACE, 12'd4, 12'd4, 1'b1,
        '{STAT_PLACED, 4'd0, 10'd0, 10'd0, 13'd4, 13'd4, 16'd0, 16'd0}},
      '{KIND_PLACE, 12'd0, 12'd5, 1'b1,
        '{STAT_INVALID, 4'd0, 10'd0, 10'd0, 13'd0, 13'd0, 16'd0, 16'd0}},
      '{KIND_PLACE, 12'd5, 12'd0, 1'b1,
        '{STAT_INVALID, 4'd0, 10'd0, 10'd0, 13'd0, 13'd0, 16'd0, 16'd0}},
      '{KIND_PLACE, 12'd1, 12'd1, 1'b0, none},
      // Too big for any atlas: a second atlas opens and stays current.
      '{KIND_PLACE, 12'd4095, 12'd4095, 1'b1,
        '{STAT_NOROOM, 4'd1, 10'd0, 10'd0, 13'd4096, 13'd4096, 16'd0, 16'd1}},
      '{KIND_CLEAR, 12'd0, 12'd0, 1'b1,
        '{STAT_CLEARED, 4'd1, 10'd0, 10'd0, 13'd0, 13'd0, 16'd0, 16'd0}},
      '{KIND_PLACE, 12'd1024, 12'd1, 1'b0, none},
      '{KIND_PLACE, 12'd1025, 12'd4, 1'b0, none},
      '{KIND_PLACE, 12'hAAA, 12'h555, 1'b0, none},
      '{KIND_PLACE, 12'h555, 12'hAAA, 1'b0, none},
      '{KIND_PLACE, 12'd3, 12'd1023, 1'b0, none},
      '{KIND_CLEAR, 12'hFFF, 12'hFFF, 1'b0, none}
    };
    wipe_skyline();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].w, dir_rows[i].h,
                   dir_rows[i].typed, dir_rows[i].exp);

    n_rand = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      load_setting(ph_cols[p], ph_rows[p], ph_pad[p], ph_max[p]);
      for (int k = 0; k < ph_cnt[p]; k++) begin
        // Idling pattern: receiver-heavy, then sender-heavy, then none.
        if (n_rand < 95) begin
          snd_pct = 37; rcv_pct = 54;
        end else if (n_rand < 190) begin
          snd_pct = 54; rcv_pct = 37;
        end else begin
          snd_pct = 0; rcv_pct = 0;
        end
        pick = $urandom_range(99);
        rk = KIND_PLACE;
        rw = 12'($urandom_range(1, ph_dim[p]));
        rh = 12'($urandom_range(1, ph_dim[p] * 2));
        if (pick < 7) begin
          rk = KIND_CLEAR;
          rw = 12'($urandom);
          rh = 12'($urandom);
        end else if (pick < 13) begin
          if ($urandom_range(1)) rw = '0;
          else rh = '0;
        end else if (pick < 20) begin
          rw = 12'($urandom);
          rh = 12'($urandom);
        end else if (pick < 24 && ph_rows[p] > 512) begin
          rh = 12'($urandom_range(256, 2000));
        end
        send_request(rk, rw, rh, 1'b0, none);
        n_rand++;
      end
    end

    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (64) @(posedge clk);
    $display("Checked %0d placed, %0d no-room, %0d invalid and %0d clear results",
             n_placed, n_noroom, n_invalid, n_cleared);
    $display("over %0d register settings, reaching %0d open atlases.",
             N_PHASES + 1, atlas_total);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
